### hw/rtl/dlsh_pkg.sv
package dlsh_pkg;

    localparam int MAX_LEVELS = 4;
    localparam int LEVEL_W    = 2;
    localparam int COUNT_W    = 3;
    localparam int COORD_W    = 24;
    localparam int MARGIN_W   = 16;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int SQ_W       = 2 * DIFF_W;
    localparam int THR_SQ_W   = 2 * COORD_W;
    localparam int DIST_W     = SQ_W + 1;
    localparam int ADDR_W     = 5;
    localparam int DATA_W     = 32;
    localparam int REG_IDX_W  = 3;

    localparam logic [REG_IDX_W-1:0] REG_CENTER_X    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_CENTER_Z    = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_LEVEL_COUNT = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_MARGIN      = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_THRESHOLD_0 = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_THRESHOLD_1 = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_THRESHOLD_2 = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_THRESHOLD_3 = 3'd7;

    localparam logic [COUNT_W-1:0]  LEVEL_COUNT_RST = 3'd4;
    localparam logic [MARGIN_W-1:0] MARGIN_RST      = 16'd1280;
    localparam logic [COORD_W-1:0]  THRESHOLD_0_RST = 24'd16384;
    localparam logic [COORD_W-1:0]  THRESHOLD_1_RST = 24'd32768;
    localparam logic [COORD_W-1:0]  THRESHOLD_2_RST = 24'd65536;
    localparam logic [COORD_W-1:0]  THRESHOLD_3_RST = 24'd131072;

    typedef struct packed {
        logic signed [COORD_W-1:0] camera_x;
        logic signed [COORD_W-1:0] camera_z;
    } camera_t;

    typedef struct packed {
        logic               visible;
        logic [LEVEL_W-1:0] level;
        logic               level_assigned;
        logic               level_changed;
    } result_t;

endpackage

### hw/rtl/distance_lod_selector_hysteresis.sv
// Detail-level selector: each camera beat gives one result beat, which passes from the input
// register through the squared-offset registers to the result register; a new camera beat can
// be taken every cycle while camera_stall is low. The pipeline is an input
// register, a stage that forms the squared x and z offsets from the chunk centre (one
// 25x25 squarer per axis), and a result register fed by the squared-distance compares
// against every level bound and the level update. Squared bounds are kept in registers that
// follow the threshold and margin registers in the next cycle, so configuration must settle
// before the next camera beat. The stored level lives in the last stage, so successive beats
// see each other's level with no gap. Registers sit at byte address 4*index of the
// APB-style port; pready is always high.
module distance_lod_selector_hysteresis
    import dlsh_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              camera_valid,
    output logic              camera_stall,
    input  camera_t           camera,
    output logic              result_valid,
    input  logic              result_stall,
    output result_t           result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    // configuration
    logic [COORD_W-1:0]  center_x_reg;
    logic [COORD_W-1:0]  center_z_reg;
    logic [COUNT_W-1:0]  level_count_reg;
    logic [MARGIN_W-1:0] margin_reg;
    logic [COORD_W-1:0]  thr_reg [MAX_LEVELS];

    logic                 wr_en;
    logic [REG_IDX_W-1:0] reg_idx;

    // squared bounds, derived from configuration
    logic [THR_SQ_W-1:0] thr_sq_reg   [MAX_LEVELS];
    logic [SQ_W-1:0]     far_sq_reg   [MAX_LEVELS];
    logic [THR_SQ_W-1:0] near_sq_reg  [MAX_LEVELS];
    logic [MAX_LEVELS-1:0] near_ok_reg;

    logic [THR_SQ_W-1:0] thr_sq_next  [MAX_LEVELS];
    logic [SQ_W-1:0]     far_sq_next  [MAX_LEVELS];
    logic [THR_SQ_W-1:0] near_sq_next [MAX_LEVELS];
    logic [MAX_LEVELS-1:0] near_ok_next;
    logic [DIFF_W-1:0]   far_sum  [MAX_LEVELS];
    logic signed [DIFF_W-1:0] near_diff [MAX_LEVELS];

    // pipeline
    logic        s1_valid_reg, s1_valid_next;
    camera_t     cam_reg;
    logic        s2_valid_reg, s2_valid_next;
    logic [SQ_W-1:0] dx2_reg, dz2_reg;
    logic [SQ_W-1:0] dx2_next, dz2_next;
    logic        out_valid_reg, out_valid_next;
    result_t     result_reg, result_next;

    logic accept, s1_fire, s2_fire, s2_ready, out_adv;

    logic signed [DIFF_W-1:0] dx, dz;
    logic [DIFF_W-1:0]        adx, adz;

    // level state
    logic               lvl_valid_reg, lvl_valid_next;
    logic [LEVEL_W-1:0] lvl_cur_reg, lvl_cur_next;

    logic [DIST_W-1:0]     d2;
    logic [MAX_LEVELS-1:0] gt_thr, gt_far, lt_near;
    logic [COUNT_W-1:0]    cnt;
    logic [LEVEL_W-1:0]    top;
    logic [COUNT_W-1:0]    pick;
    logic [LEVEL_W-1:0]    lc;
    logic                  vis;

    // configuration port
    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[ADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg    <= '0;
            center_z_reg    <= '0;
            level_count_reg <= LEVEL_COUNT_RST;
            margin_reg      <= MARGIN_RST;
            thr_reg[0]      <= THRESHOLD_0_RST;
            thr_reg[1]      <= THRESHOLD_1_RST;
            thr_reg[2]      <= THRESHOLD_2_RST;
            thr_reg[3]      <= THRESHOLD_3_RST;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_CENTER_X:    center_x_reg    <= pwdata[COORD_W-1:0];
                REG_CENTER_Z:    center_z_reg    <= pwdata[COORD_W-1:0];
                REG_LEVEL_COUNT: level_count_reg <= pwdata[COUNT_W-1:0];
                REG_MARGIN:      margin_reg      <= pwdata[MARGIN_W-1:0];
                REG_THRESHOLD_0: thr_reg[0]      <= pwdata[COORD_W-1:0];
                REG_THRESHOLD_1: thr_reg[1]      <= pwdata[COORD_W-1:0];
                REG_THRESHOLD_2: thr_reg[2]      <= pwdata[COORD_W-1:0];
                REG_THRESHOLD_3: thr_reg[3]      <= pwdata[COORD_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_CENTER_X:    prdata = {{(DATA_W-COORD_W){1'b0}}, center_x_reg};
            REG_CENTER_Z:    prdata = {{(DATA_W-COORD_W){1'b0}}, center_z_reg};
            REG_LEVEL_COUNT: prdata = {{(DATA_W-COUNT_W){1'b0}}, level_count_reg};
            REG_MARGIN:      prdata = {{(DATA_W-MARGIN_W){1'b0}}, margin_reg};
            REG_THRESHOLD_0: prdata = {{(DATA_W-COORD_W){1'b0}}, thr_reg[0]};
            REG_THRESHOLD_1: prdata = {{(DATA_W-COORD_W){1'b0}}, thr_reg[1]};
            REG_THRESHOLD_2: prdata = {{(DATA_W-COORD_W){1'b0}}, thr_reg[2]};
            REG_THRESHOLD_3: prdata = {{(DATA_W-COORD_W){1'b0}}, thr_reg[3]};
            default:         prdata = '0;
        endcase
    end

    // squared bounds: plain, far side (plus margin) and near side (minus margin)
    always_comb
    begin
        for (int i = 0; i < MAX_LEVELS; i++)
        begin
            far_sum[i]      = {1'b0, thr_reg[i]} + {{(DIFF_W-MARGIN_W){1'b0}}, margin_reg};
            near_diff[i]    = $signed({1'b0, thr_reg[i]})
                            - $signed({{(DIFF_W-MARGIN_W){1'b0}}, margin_reg});
            thr_sq_next[i]  = thr_reg[i] * thr_reg[i];
            far_sq_next[i]  = far_sum[i] * far_sum[i];
            near_sq_next[i] = near_diff[i][COORD_W-1:0] * near_diff[i][COORD_W-1:0];
            // a near bound at or below zero never triggers
            near_ok_next[i] = (near_diff[i] > 0);
        end
    end

    always_ff @(posedge clk)
    begin
        thr_sq_reg  <= thr_sq_next;
        far_sq_reg  <= far_sq_next;
        near_sq_reg <= near_sq_next;
        near_ok_reg <= near_ok_next;
    end

    // handshake
    assign out_adv       = !out_valid_reg || !result_stall;
    assign s2_fire       = s2_valid_reg && out_adv;
    assign s2_ready      = !s2_valid_reg || out_adv;
    assign s1_fire       = s1_valid_reg && s2_ready;
    assign camera_stall  = s1_valid_reg && !s2_ready;
    assign accept        = camera_valid && !camera_stall;

    assign s1_valid_next  = accept || (s1_valid_reg && !s2_ready);
    assign s2_valid_next  = s1_fire || (s2_valid_reg && !out_adv);
    assign out_valid_next = s2_fire || (out_valid_reg && result_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            lvl_valid_reg <= 1'b0;
            lvl_cur_reg   <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
            if (s2_fire)
            begin
                lvl_valid_reg <= lvl_valid_next;
                lvl_cur_reg   <= lvl_cur_next;
            end
        end
    end

    // stage 1: offsets from the centre, squared
    always_comb
    begin
        dx  = $signed({cam_reg.camera_x[COORD_W-1], cam_reg.camera_x})
            - $signed({center_x_reg[COORD_W-1], center_x_reg});
        dz  = $signed({cam_reg.camera_z[COORD_W-1], cam_reg.camera_z})
            - $signed({center_z_reg[COORD_W-1], center_z_reg});
        // most negative offset wraps to its magnitude as an unsigned value
        adx = dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
        adz = dz[DIFF_W-1] ? DIFF_W'(-dz) : DIFF_W'(dz);
        dx2_next = adx * adx;
        dz2_next = adz * adz;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            cam_reg <= camera;
        if (s1_fire)
        begin
            dx2_reg <= dx2_next;
            dz2_reg <= dz2_next;
        end
        if (s2_fire)
            result_reg <= result_next;
    end

    // stage 2: compares and level update
    always_comb
    begin
        d2 = {1'b0, dx2_reg} + {1'b0, dz2_reg};
        for (int i = 0; i < MAX_LEVELS; i++)
        begin
            gt_thr[i]  = d2 > {{(DIST_W-THR_SQ_W){1'b0}}, thr_sq_reg[i]};
            gt_far[i]  = d2 > {1'b0, far_sq_reg[i]};
            lt_near[i] = near_ok_reg[i] && (d2 < {{(DIST_W-THR_SQ_W){1'b0}}, near_sq_reg[i]});
        end

        if (level_count_reg == '0)
            cnt = COUNT_W'(1);
        else if (level_count_reg > COUNT_W'(MAX_LEVELS))
            cnt = COUNT_W'(MAX_LEVELS);
        else
            cnt = level_count_reg;
        top = LEVEL_W'(cnt - COUNT_W'(1));

        // highest bound exceeded wins
        pick = '0;
        for (int i = 0; i < MAX_LEVELS; i++)
        begin
            if ((COUNT_W'(i) < cnt) && gt_thr[i])
                pick = COUNT_W'(i + 1);
        end

        vis            = 1'b1;
        lc             = lvl_cur_reg;
        lvl_valid_next = lvl_valid_reg;
        lvl_cur_next   = lvl_cur_reg;
        result_next    = '0;

        if (!lvl_valid_reg)
        begin
            if (pick >= cnt)
                vis = 1'b0;
            else
            begin
                lvl_valid_next = 1'b1;
                lvl_cur_next   = pick[LEVEL_W-1:0];
            end
            result_next.level_changed = lvl_valid_next;
        end
        else
        begin
            // count lowered below the stored level
            if ({1'b0, lvl_cur_reg} >= cnt)
                lc = top;
            if (gt_far[lc])
            begin
                if (lc == top)
                    vis = 1'b0;
                else
                    lc = lc + LEVEL_W'(1);
            end
            if (vis && (lc != '0) && lt_near[lc - LEVEL_W'(1)])
                lc = lc - LEVEL_W'(1);
            lvl_cur_next = lc;
            result_next.level_changed = (lc != lvl_cur_reg);
        end

        result_next.visible        = vis;
        result_next.level_assigned = lvl_valid_next;
        result_next.level          = lvl_valid_next ? lvl_cur_next : '0;
    end

    assign result_valid = out_valid_reg;
    assign result       = result_reg;

endmodule

### hw/rtl/dlsh_checker.sv
module dlsh_checker
    import dlsh_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              result_valid,
    input logic              result_stall,
    input result_t           result
);

    // set once an assigned level has left the block
    logic seen_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seen_reg <= 1'b0;
        else if (result_valid && !result_stall && result.level_assigned)
            seen_reg <= 1'b1;
    end

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("stalled result beat changed");

    a_unassigned_level: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.level_assigned |-> result.level == '0 && !result.level_changed)
        else $error("unassigned beat carries a level or a change");

    a_assigned_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && seen_reg |-> result.level_assigned)
        else $error("level assignment was lost");

    a_change_visible: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.level_assigned |-> !result.visible)
        else $error("unassigned beat marked visible");

endmodule

bind distance_lod_selector_hysteresis dlsh_checker u_dlsh_checker (.*);

### tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top
    import dlsh_pkg::*;
();

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              camera_valid = 1'b0;
    logic              camera_stall;
    camera_t           camera = '0;
    logic              result_valid;
    logic              result_stall = 1'b0;
    result_t           result;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    distance_lod_selector_hysteresis dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .camera_valid (camera_valid),
        .camera_stall (camera_stall),
        .camera       (camera),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #5 clk = ~clk;

    // shadow copy of the register file
    longint  cen_x = 0;
    longint  cen_z = 0;
    longint  lvl_cnt = LEVEL_COUNT_RST;
    longint  hyst = MARGIN_RST;
    longint  thr [4] = '{THRESHOLD_0_RST, THRESHOLD_1_RST, THRESHOLD_2_RST, THRESHOLD_3_RST};

    // predicted detail-level state
    bit      lvl_set = 1'b0;
    int      lvl_now = 0;

    camera_t cam_feed [$];
    result_t level_expect [$];
    result_t want;

    int      send_gap_pct = 0;
    int      recv_gap_pct = 0;
    int      mismatches = 0;

    bit      hold_req = 1'b0;
    bit      hold_done = 1'b0;
    int      hold_left = 0;

    function automatic result_t predict_level(camera_t c);
        longint  dx;
        longint  dz;
        longint  d2;
        longint  far_b;
        longint  near_b;
        int      cnt;
        int      pick;
        int      prior;
        bit      vis;
        bit      chg;
        bit      found;
        result_t r;
        dx = longint'(c.camera_x) - cen_x;
        dz = longint'(c.camera_z) - cen_z;
        d2 = dx * dx + dz * dz;
        cnt = (lvl_cnt == 0) ? 1 : (lvl_cnt > MAX_LEVELS) ? MAX_LEVELS : int'(lvl_cnt);
        vis = 1'b1;
        chg = 1'b0;
        if (!lvl_set)
        begin
            // scan from the top bound down for the first one exceeded
            pick = 0;
            found = 1'b0;
            for (int i = cnt - 1; i >= 0; i--)
            begin
                if (!found && d2 > thr[i] * thr[i])
                begin
                    pick = i + 1;
                    found = 1'b1;
                end
            end
            if (pick >= cnt)
            begin
                vis = 1'b0;
            end
            else
            begin
                lvl_set = 1'b1;
                lvl_now = pick;
                chg = 1'b1;
            end
        end
        else
        begin
            prior = lvl_now;
            if (lvl_now >= cnt)
                lvl_now = cnt - 1;
            far_b = thr[lvl_now] + hyst;
            if (d2 > far_b * far_b)
            begin
                if (lvl_now == cnt - 1)
                    vis = 1'b0;
                else
                    lvl_now++;
            end
            if (vis && lvl_now > 0)
            begin
                // a near bound at or below zero never steps down
                near_b = thr[lvl_now - 1] - hyst;
                if (near_b > 0 && d2 < near_b * near_b)
                    lvl_now--;
            end
            chg = (lvl_now != prior);
        end
        r.visible        = vis;
        r.level          = lvl_set ? LEVEL_W'(lvl_now) : '0;
        r.level_assigned = lvl_set;
        r.level_changed  = chg;
        return r;
    endfunction

    // camera driver
    always @(posedge clk)
    begin
        if (camera_valid && !camera_stall)
            level_expect = {level_expect, predict_level(camera)};
        if (!camera_valid || !camera_stall)
        begin
            if (cam_feed.size() != 0 && $urandom_range(99) >= send_gap_pct)
            begin
                camera       <= cam_feed.pop_front();
                camera_valid <= 1'b1;
            end
            else
            begin
                camera_valid <= 1'b0;
            end
        end
    end

    // result monitor and receiver stall
    always @(posedge clk)
    begin
        if (result_valid && !result_stall)
        begin
            if (level_expect.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected beat: vis %0b lvl %0d asg %0b chg %0b",
                             $time, result.visible, result.level, result.level_assigned,
                             result.level_changed);
            end
            else
            begin
                want = level_expect.pop_front();
                if (result.visible !== want.visible || result.level !== want.level ||
                    result.level_assigned !== want.level_assigned ||
                    result.level_changed !== want.level_changed)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"%0t: expected vis %0b lvl %0d asg %0b chg %0b,",
                                  " got vis %0b lvl %0d asg %0b chg %0b"},
                                 $time, want.visible, want.level, want.level_assigned,
                                 want.level_changed, result.visible, result.level,
                                 result.level_assigned, result.level_changed);
                end
            end
        end
        result_stall <= (hold_left > 0) || ($urandom_range(99) < recv_gap_pct);
    end

    // long receiver hold-off so the pipeline backs up into the input
    always @(posedge clk)
    begin
        if (hold_req && !hold_done)
        begin
            hold_left <= 300;
            hold_done <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_CENTER_X:    cen_x = longint'($signed(val[23:0]));
            REG_CENTER_Z:    cen_z = longint'($signed(val[23:0]));
            REG_LEVEL_COUNT: lvl_cnt = longint'(val[COUNT_W-1:0]);
            REG_MARGIN:      hyst = longint'(val[MARGIN_W-1:0]);
            REG_THRESHOLD_0: thr[0] = longint'(val[23:0]);
            REG_THRESHOLD_1: thr[1] = longint'(val[23:0]);
            REG_THRESHOLD_2: thr[2] = longint'(val[23:0]);
            REG_THRESHOLD_3: thr[3] = longint'(val[23:0]);
            default: ;
        endcase
    endtask

    task automatic add_cam(input longint x, input longint z);
        camera_t c;
        c.camera_x = x[23:0];
        c.camera_z = z[23:0];
        cam_feed = {cam_feed, c};
    endtask

    // mostly positions close to one of the level bounds, some pure noise
    task automatic add_random_cam();
        camera_t c;
        longint  r;
        longint  side;
        if ($urandom_range(99) < 20)
        begin
            c.camera_x = 24'($urandom);
            c.camera_z = 24'($urandom);
            cam_feed = {cam_feed, c};
        end
        else
        begin
            r = thr[$urandom_range(3)] + longint'($urandom_range(0, 32'(4 * hyst + 1024)))
                - 2 * hyst - 512;
            if (r < 0)
                r = 0;
            if ($urandom_range(1))
                r = -r;
            side = longint'($urandom_range(0, 255));
            if ($urandom_range(1))
                add_cam(cen_x + r, cen_z + side);
            else
                add_cam(cen_x + side, cen_z + r);
        end
    endtask

    task automatic random_config(input int p);
        longint t;
        write_reg(REG_CENTER_X, $urandom);
        write_reg(REG_CENTER_Z, $urandom);
        write_reg(REG_LEVEL_COUNT, $urandom);
        write_reg(REG_MARGIN, (p % 3 == 0) ? $urandom : $urandom_range(0, 3000));
        t = $urandom_range(0, 30000);
        for (int i = 0; i < MAX_LEVELS; i++)
        begin
            if (p % 4 == 3)
                write_reg(REG_IDX_W'(REG_THRESHOLD_0 + i), $urandom);
            else
                write_reg(REG_IDX_W'(REG_THRESHOLD_0 + i), 32'(t));
            t = t + $urandom_range(0, 80000);
        end
    endtask

    task automatic drain_beats();
        while (cam_feed.size() != 0 || camera_valid || level_expect.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_gap_pct = 15;
        recv_gap_pct = 66;

        // reset bounds are 16384/32768/65536/131072; first beat is too far to get a level
        add_cam(8388607, 8388607);
        add_cam(30000, 0);
        add_cam(0, 0);
        add_cam(25600, 0);
        add_cam(0, 51200);
        add_cam(153600, 0);
        add_cam(153600, 0);
        add_cam(2560, 0);
        add_cam(8388607, -8388608);
        drain_beats();

        // fewer levels than the stored one: clamp shows up as a change
        write_reg(REG_LEVEL_COUNT, 32'd2);
        add_cam(0, 0);
        add_cam(25600, 0);
        drain_beats();

        // extreme registers, margin larger than the zero thresholds 0 and 2
        write_reg(REG_CENTER_X, 32'h0080_0000);
        write_reg(REG_CENTER_Z, 32'h007F_FFFF);
        write_reg(REG_MARGIN, 32'h0000_FFFF);
        write_reg(REG_THRESHOLD_0, 32'd0);
        write_reg(REG_THRESHOLD_1, 32'h00FF_FFFF);
        write_reg(REG_THRESHOLD_2, 32'd0);
        write_reg(REG_THRESHOLD_3, 32'h00FF_FFFF);
        write_reg(REG_LEVEL_COUNT, 32'd0);
        add_cam(8388607, -8388608);
        add_cam(-8388608, 8388607);
        add_cam(-8388608 + 1000, 8388607);
        drain_beats();

        write_reg(REG_LEVEL_COUNT, 32'd7);
        add_cam(-8388608, 8388607);
        add_cam(8388607, -8388608);
        add_cam(8388607, -8388608);
        add_cam(-8388608, 8388607);
        drain_beats();

        for (int p = 0; p < 8; p++)
        begin
            if (p < 3)
            begin
                send_gap_pct = 15;
                recv_gap_pct = 66;
            end
            else if (p < 6)
            begin
                send_gap_pct = 66;
                recv_gap_pct = 15;
            end
            else
            begin
                send_gap_pct = 0;
                recv_gap_pct = 0;
            end
            random_config(p);
            if (p == 6)
                hold_req <= 1'b1;
            for (int n = 0; n < 60; n++)
                add_random_cam();
            drain_beats();
        end

        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/dlsh_pkg.sv
hw/rtl/distance_lod_selector_hysteresis.sv
hw/rtl/dlsh_checker.sv
tb/tb_top.sv
